[rtl/core/stt_pkg.sv]
// Types, token kind codes, character codes and byte classifiers for the source text tokenizer.
package stt_pkg;

    // Token kinds
    localparam logic [5:0] KIND_IDENT   = 6'd0;
    localparam logic [5:0] KIND_NUMBER  = 6'd1;
    localparam logic [5:0] KIND_DECIMAL = 6'd2;
    localparam logic [5:0] KIND_KW_BASE = 6'd3;
    localparam logic [5:0] KIND_SEMI    = 6'd10;
    localparam logic [5:0] KIND_QUOTE   = 6'd11;
    localparam logic [5:0] KIND_LPAREN  = 6'd12;
    localparam logic [5:0] KIND_RPAREN  = 6'd13;
    localparam logic [5:0] KIND_LBRACE  = 6'd14;
    localparam logic [5:0] KIND_RBRACE  = 6'd15;
    localparam logic [5:0] KIND_COMMA   = 6'd16;
    localparam logic [5:0] KIND_ASSIGN  = 6'd17;
    localparam logic [5:0] KIND_LESS    = 6'd19;
    localparam logic [5:0] KIND_GREATER = 6'd20;
    localparam logic [5:0] KIND_AMP     = 6'd21;
    localparam logic [5:0] KIND_BAR     = 6'd23;
    localparam logic [5:0] KIND_BANG    = 6'd25;
    localparam logic [5:0] KIND_STAR    = 6'd27;
    localparam logic [5:0] KIND_PLUS    = 6'd29;
    localparam logic [5:0] KIND_MINUS   = 6'd31;
    localparam logic [5:0] KIND_SLASH   = 6'd33;
    localparam logic [5:0] KIND_ERROR   = 6'd35;
    localparam logic [5:0] KIND_NONE    = 6'd0;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Keywords, right-aligned ASCII, if else int float for once return
    localparam int         KW_COUNT = 7;
    localparam int         KW_BITS  = 48;
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0000_6966,
        48'h0000_656C_7365,
        48'h0000_0069_6E74,
        48'h0066_6C6F_6174,
        48'h0000_0066_6F72,
        48'h0000_6F6E_6365,
        48'h7265_7475_726E
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd4, 4'd3, 4'd5, 4'd3, 4'd4, 4'd6};

    localparam logic [15:0] LEN_ONE = 16'd1;
    localparam logic [15:0] LEN_TWO = 16'd2;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_IDENT   = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_OP      = 5'b01000,
        MODE_COMMENT = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        run_last;
        logic        source_done;
    } token_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Kind of a lone operator character, KIND_NONE when it is not one.
    function automatic logic [5:0] op_single(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            CH_EQUALS: k = KIND_ASSIGN;
            CH_AMP:    k = KIND_AMP;
            CH_BAR:    k = KIND_BAR;
            CH_BANG:   k = KIND_BANG;
            CH_STAR:   k = KIND_STAR;
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_SLASH:  k = KIND_SLASH;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Second character that turns an operator into its two-character form.
    function automatic logic [7:0] op_partner(input logic [7:0] c);
        return ((c == CH_AMP) || (c == CH_BAR)) ? c : CH_EQUALS;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            CH_SEMI:    k = KIND_SEMI;
            CH_QUOTE:   k = KIND_QUOTE;
            CH_LPAREN:  k = KIND_LPAREN;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_LBRACE:  k = KIND_LBRACE;
            CH_RBRACE:  k = KIND_RBRACE;
            CH_COMMA:   k = KIND_COMMA;
            CH_LESS:    k = KIND_LESS;
            CH_GREATER: k = KIND_GREATER;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

[rtl/core/source_text_tokenizer_unit.sv]
// Source text tokenizer: one byte per word in, one token per word out.
// The tokens that a byte completes are written into the output queue when the byte is accepted.
// Throughput: one byte per cycle; the scanner state updates in the accepting cycle and the
// tokens go into a four-entry output queue, so s_tready drops only when fewer than two
// queue entries are free. A byte can give up to two tokens.
// Reset: synchronous active-low aresetn empties the queue and returns the scanner to idle.
module source_text_tokenizer_unit #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // source_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] token_kind, [21:6] token_start, [37:22] token_length
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] source_done
);
    import stt_pkg::*;

    localparam int WIN_BITS = 8 * KEYWORD_CHARS;

    // Scanner state
    mode_t                   mode_reg, mode_next;
    logic [7:0]              pend_reg, pend_next;
    logic [15:0]             start_reg, start_next;
    logic [15:0]             run_len_reg, run_len_next;
    logic [WIN_BITS-1:0]     win_reg, win_next;
    logic                    dot_reg, dot_next;
    logic [POSITION_BITS-1:0] byte_pos_reg, byte_pos_next;

    // Output queue
    token_t      queue_mem [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;

    logic        accept, pop;
    logic [7:0]  c;
    logic        last;
    logic [15:0] pos16;
    logic [15:0] ext_len;
    logic [WIN_BITS-1:0] ext_win;
    logic        fresh;
    token_t      a_tok, b_tok, tok0, tok1;
    logic        a_valid, b_valid;
    logic [1:0]  n_tok;

    function automatic logic [5:0] kw_kind(input logic [15:0] len,
                                           input logic [WIN_BITS-1:0] win);
        logic [5:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if ((len == 16'(KW_LEN[k])) && (win[KW_BITS-1:0] == KW_TEXT[k]) &&
                ((win >> KW_BITS) == '0)) begin
                kind = KIND_KW_BASE + 6'(k);
            end
        end
        return kind;
    endfunction

    generate
        if (POSITION_BITS >= 16) begin : g_pos_wide
            assign pos16 = byte_pos_reg[15:0];
        end else begin : g_pos_narrow
            assign pos16 = {{(16 - POSITION_BITS){1'b0}}, byte_pos_reg};
        end
    endgenerate

    assign c      = s_tdata;
    assign last   = s_tlast;
    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;

    assign ext_len = (run_len_reg == LEN_MAX) ? run_len_reg : run_len_reg + LEN_ONE;
    assign ext_win = {win_reg[WIN_BITS-9:0], c};

    always_comb begin
        mode_next    = mode_reg;
        pend_next    = pend_reg;
        start_next   = start_reg;
        run_len_next = run_len_reg;
        win_next     = win_reg;
        dot_next     = dot_reg;
        a_tok        = '0;
        b_tok        = '0;
        a_valid      = 1'b0;
        b_valid      = 1'b0;
        fresh        = 1'b0;

        // Close or continue whatever run is open.
        case (mode_reg)
            MODE_IDENT: begin
                if (is_space(c) || (c == CH_COMMA) || (c == CH_SEMI) ||
                    (c == CH_LPAREN) || (c == CH_RPAREN)) begin
                    a_valid      = 1'b1;
                    a_tok.kind   = kw_kind(run_len_reg, win_reg);
                    a_tok.start  = start_reg;
                    a_tok.length = run_len_reg;
                    mode_next    = MODE_IDLE;
                    fresh        = !is_space(c);
                end else begin
                    run_len_next = ext_len;
                    win_next     = ext_win;
                    if (last) begin
                        a_valid      = 1'b1;
                        a_tok.kind   = kw_kind(ext_len, ext_win);
                        a_tok.start  = start_reg;
                        a_tok.length = ext_len;
                        mode_next    = MODE_IDLE;
                    end
                end
            end
            MODE_NUMBER: begin
                if (is_digit(c) || (c == CH_DOT)) begin
                    run_len_next = ext_len;
                    win_next     = ext_win;
                    if (c == CH_DOT) begin
                        dot_next = 1'b1;
                    end
                    if (last) begin
                        a_valid      = 1'b1;
                        a_tok.kind   = dot_next ? KIND_DECIMAL : KIND_NUMBER;
                        a_tok.start  = start_reg;
                        a_tok.length = ext_len;
                        mode_next    = MODE_IDLE;
                    end
                end else begin
                    a_valid      = 1'b1;
                    a_tok.kind   = dot_reg ? KIND_DECIMAL : KIND_NUMBER;
                    a_tok.start  = start_reg;
                    a_tok.length = run_len_reg;
                    mode_next    = MODE_IDLE;
                    fresh        = 1'b1;
                end
            end
            MODE_OP: begin
                mode_next   = MODE_IDLE;
                a_tok.start = start_reg;
                if ((pend_reg == CH_SLASH) && (c == CH_SLASH)) begin
                    mode_next = MODE_COMMENT;
                end else if (c == op_partner(pend_reg)) begin
                    a_valid      = 1'b1;
                    a_tok.kind   = op_single(pend_reg) + 6'd1;
                    a_tok.length = LEN_TWO;
                end else begin
                    a_valid      = 1'b1;
                    a_tok.kind   = op_single(pend_reg);
                    a_tok.length = LEN_ONE;
                    fresh        = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (c == CH_NL) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
                fresh     = 1'b1;
            end
        endcase

        // Scan the byte as the start of something new.
        b_tok.start  = pos16;
        b_tok.length = LEN_ONE;
        if (fresh && !(is_space(c) || (c == CH_NUL))) begin
            if (punct_kind(c) != KIND_NONE) begin
                b_valid    = 1'b1;
                b_tok.kind = punct_kind(c);
            end else if (op_single(c) != KIND_NONE) begin
                if (last) begin
                    b_valid    = 1'b1;
                    b_tok.kind = KIND_ERROR;
                end else begin
                    mode_next  = MODE_OP;
                    pend_next  = c;
                    start_next = pos16;
                end
            end else if (is_alpha(c) || is_digit(c)) begin
                mode_next    = is_alpha(c) ? MODE_IDENT : MODE_NUMBER;
                start_next   = pos16;
                run_len_next = LEN_ONE;
                win_next     = WIN_BITS'(c);
                dot_next     = 1'b0;
                if (last) begin
                    // No keyword is a single character.
                    b_valid    = 1'b1;
                    b_tok.kind = is_alpha(c) ? KIND_IDENT : KIND_NUMBER;
                    mode_next  = MODE_IDLE;
                end
            end else if (c == CH_DOT) begin
                b_valid    = 1'b1;
                b_tok.kind = KIND_DECIMAL;
            end else begin
                b_valid    = 1'b1;
                b_tok.kind = KIND_IDENT;
            end
        end

        // Order the tokens and flag the final one of this byte.
        tok0  = a_valid ? a_tok : b_tok;
        tok1  = b_tok;
        n_tok = {1'b0, a_valid} + {1'b0, b_valid};
        if (n_tok == 2'd2) begin
            tok1.run_last    = 1'b1;
            tok1.source_done = last;
        end else begin
            tok0.run_last    = 1'b1;
            tok0.source_done = last;
        end

        if (last) begin
            mode_next     = MODE_IDLE;
            pend_next     = '0;
            start_next    = '0;
            run_len_next  = '0;
            win_next      = '0;
            dot_next      = 1'b0;
            byte_pos_next = '0;
        end else begin
            byte_pos_next = byte_pos_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            pend_reg     <= '0;
            start_reg    <= '0;
            run_len_reg  <= '0;
            win_reg      <= '0;
            dot_reg      <= 1'b0;
            byte_pos_reg <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            pend_reg     <= pend_next;
            start_reg    <= start_next;
            run_len_reg  <= run_len_next;
            win_reg      <= win_next;
            dot_reg      <= dot_next;
            byte_pos_reg <= byte_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (n_tok != 2'd0) begin
                queue_mem[wr_ptr_reg] <= tok0;
            end
            if (n_tok == 2'd2) begin
                queue_mem[wr_ptr_reg + 2'd1] <= tok1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + n_tok;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (accept ? {1'b0, n_tok} : 3'd0) - {2'b00, pop};
        end
    end

    // Room for two words is kept so that any byte can be taken.
    assign s_tready = (count_reg <= 3'd2);
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {2'b00, queue_mem[rd_ptr_reg].length, queue_mem[rd_ptr_reg].start,
                       queue_mem[rd_ptr_reg].kind};
    assign m_tlast  = queue_mem[rd_ptr_reg].run_last;
    assign m_tuser  = queue_mem[rd_ptr_reg].source_done;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the source text tokenizer unit.
`timescale 1ns / 1ps

module testbench;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] char_in
    logic        s_tlast  = 1'b0;   // source_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [5:0] token_kind, [21:6] token_start, [37:22] token_length
    logic        m_tlast;           // run_last
    logic        m_tuser;           // [0] source_done

    source_text_tokenizer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Scanner state as the testbench sees it.
    mode_t       scan_mode = MODE_IDLE;
    logic [7:0]  pend_op   = 8'd0;
    logic [15:0] tok_start = 16'd0;
    logic [15:0] run_len   = 16'd0;
    logic [47:0] kw_win    = 48'd0;
    logic        dot_seen  = 1'b0;
    logic [15:0] scan_pos  = 16'd0;

    token_t expected_tokens[$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    int     hold_cycles    = 0;
    bit     send_idle_en   = 1'b1;
    bit     recv_idle_en   = 1'b1;

    string      keyword_words [7] = '{"if", "else", "int", "float", "for", "once", "return"};
    string      double_ops    [8] = '{"==", "&&", "||", "!=", "*=", "+=", "-=", "/="};
    string      single_ops        = "=&|!*+-/";
    string      punct_chars       = ";\"(){},<>";
    logic [7:0] blank_bytes   [7] = '{CH_SPACE, CH_TAB, CH_NL, 8'h0B, 8'h0C, CH_CR, CH_NUL};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic blank_char(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Kind of a one-character token; is_op marks the characters that may pair up.
    function automatic logic [5:0] char_kind(input logic [7:0] c, output logic is_op);
        is_op = 1'b1;
        case (c)
            CH_EQUALS: return KIND_ASSIGN;
            CH_AMP:    return KIND_AMP;
            CH_BAR:    return KIND_BAR;
            CH_BANG:   return KIND_BANG;
            CH_STAR:   return KIND_STAR;
            CH_PLUS:   return KIND_PLUS;
            CH_MINUS:  return KIND_MINUS;
            CH_SLASH:  return KIND_SLASH;
            default:   is_op = 1'b0;
        endcase
        case (c)
            CH_SEMI:    return KIND_SEMI;
            CH_QUOTE:   return KIND_QUOTE;
            CH_LPAREN:  return KIND_LPAREN;
            CH_RPAREN:  return KIND_RPAREN;
            CH_LBRACE:  return KIND_LBRACE;
            CH_RBRACE:  return KIND_RBRACE;
            CH_COMMA:   return KIND_COMMA;
            CH_LESS:    return KIND_LESS;
            CH_GREATER: return KIND_GREATER;
            default:    return KIND_NONE;
        endcase
    endfunction

    // A keyword matches only when the whole run has the keyword's length.
    function automatic logic [5:0] word_kind();
        logic [47:0] spelled;
        for (int k = 0; k < 7; k++) begin
            spelled = 48'd0;
            for (int i = 0; i < keyword_words[k].len(); i++)
                spelled = {spelled[39:0], keyword_words[k][i]};
            if (run_len == keyword_words[k].len() && kw_win == spelled)
                return 6'(KIND_KW_BASE + k);
        end
        return KIND_IDENT;
    endfunction

    function automatic token_t make_token(input logic [5:0] kind, input logic [15:0] start,
                                          input logic [15:0] len);
        token_t t;
        t.kind        = kind;
        t.start       = start;
        t.length      = len;
        t.run_last    = 1'b0;
        t.source_done = 1'b0;
        return t;
    endfunction

    function automatic void grow_run(input logic [7:0] c);
        if (run_len != LEN_MAX)
            run_len = run_len + 16'd1;
        kw_win = {kw_win[39:0], c};
    endfunction

    // Works out the tokens that one accepted source byte gives.
    task automatic tokenize_byte(input logic [7:0] c, input logic last);
        token_t      found[$];
        logic [15:0] here;
        logic [5:0]  k;
        logic        is_op;
        logic        fresh;
        here     = scan_pos;
        scan_pos = scan_pos + 16'd1;
        fresh    = 1'b0;
        case (scan_mode)
            MODE_IDENT: begin
                if (blank_char(c) || c == CH_COMMA || c == CH_SEMI ||
                    c == CH_LPAREN || c == CH_RPAREN) begin
                    found.push_back(make_token(word_kind(), tok_start, run_len));
                    scan_mode = MODE_IDLE;
                    fresh     = !blank_char(c);
                end else begin
                    grow_run(c);
                    if (last)
                        found.push_back(make_token(word_kind(), tok_start, run_len));
                end
            end
            MODE_NUMBER: begin
                if (digit_char(c) || c == CH_DOT) begin
                    grow_run(c);
                    if (c == CH_DOT)
                        dot_seen = 1'b1;
                    if (last)
                        found.push_back(make_token(dot_seen ? KIND_DECIMAL : KIND_NUMBER,
                                                   tok_start, run_len));
                end else begin
                    found.push_back(make_token(dot_seen ? KIND_DECIMAL : KIND_NUMBER,
                                               tok_start, run_len));
                    scan_mode = MODE_IDLE;
                    fresh     = 1'b1;
                end
            end
            MODE_OP: begin
                scan_mode = MODE_IDLE;
                k = char_kind(pend_op, is_op);
                if (pend_op == CH_SLASH && c == CH_SLASH) begin
                    scan_mode = MODE_COMMENT;
                end else if (c == ((pend_op == CH_AMP || pend_op == CH_BAR) ? pend_op
                                                                            : CH_EQUALS)) begin
                    found.push_back(make_token(k + 6'd1, tok_start, LEN_TWO));
                end else begin
                    found.push_back(make_token(k, tok_start, LEN_ONE));
                    fresh = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (c == CH_NL)
                    scan_mode = MODE_IDLE;
            end
            default: fresh = 1'b1;
        endcase

        if (fresh && !blank_char(c) && c != CH_NUL) begin
            k = char_kind(c, is_op);
            if (is_op) begin
                if (last) begin
                    found.push_back(make_token(KIND_ERROR, here, LEN_ONE));
                end else begin
                    scan_mode = MODE_OP;
                    pend_op   = c;
                    tok_start = here;
                end
            end else if (k != KIND_NONE) begin
                found.push_back(make_token(k, here, LEN_ONE));
            end else if (letter_char(c) || digit_char(c)) begin
                scan_mode = letter_char(c) ? MODE_IDENT : MODE_NUMBER;
                tok_start = here;
                run_len   = LEN_ONE;
                kw_win    = {40'd0, c};
                dot_seen  = 1'b0;
                if (last)
                    found.push_back(make_token(letter_char(c) ? word_kind() : KIND_NUMBER,
                                               here, LEN_ONE));
            end else if (c == CH_DOT) begin
                found.push_back(make_token(KIND_DECIMAL, here, LEN_ONE));
            end else begin
                found.push_back(make_token(KIND_IDENT, here, LEN_ONE));
            end
        end

        if (found.size() > 0) begin
            found[found.size()-1].run_last    = 1'b1;
            found[found.size()-1].source_done = last;
        end
        foreach (found[i])
            expected_tokens.push_back(found[i]);

        // The next source starts from a clean scanner.
        if (last) begin
            scan_mode = MODE_IDLE;
            pend_op   = 8'd0;
            tok_start = 16'd0;
            run_len   = 16'd0;
            kw_win    = 48'd0;
            dot_seen  = 1'b0;
            scan_pos  = 16'd0;
        end
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Predict first, so the order of expectations holds whatever the latency.
    always @(posedge aclk) begin
        token_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected token, expected none, actual kind %0d start %0d len %0d",
                             $time, m_tdata[5:0], m_tdata[21:6], m_tdata[37:22]);
                    mismatch_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    compare_field("token_kind", want.kind, m_tdata[5:0]);
                    compare_field("token_start", want.start, m_tdata[21:6]);
                    compare_field("token_length", want.length, m_tdata[37:22]);
                    compare_field("run_last", want.run_last, m_tlast);
                    compare_field("source_done", want.source_done, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d tokens outstanding", $time, expected_tokens.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: a random stall before each word while recv_idle_en is set, or a long hold when one is asked for.
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            gap = recv_idle_en ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = send_idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_source(input logic [7:0] src[$]);
        for (int i = 0; i < src.size(); i++)
            send_byte(src[i], i == src.size() - 1);
    endtask

    task automatic push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z))
                                    : 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'($urandom_range(CH_ZERO, CH_NINE));
    endfunction

    // Byte extremes, errors on a final operator, comments, lone dots and quotes.
    task automatic test_special_cases;
        logic [7:0] src[$];
        src = '{CH_NUL, 8'hFF};
        send_source(src);
        src.delete();
        push_text(src, "x//c\n=");
        send_source(src);
        src.delete();
        push_text(src, "a+=1.5;");
        send_source(src);
        src.delete();
        push_text(src, "12a");
        src.push_back(CH_NUL);
        src.push_back(CH_DOT);
        send_source(src);
        src.delete();
        push_text(src, "!x");
        send_source(src);
        src.delete();
        push_text(src, "\".");
        send_source(src);
        src.delete();
        push_text(src, "/");
        send_source(src);
        src.delete();
        push_text(src, "x ");
        send_source(src);
    endtask

    task automatic test_all_kinds;
        logic [7:0] src[$];
        push_text(src, "if else int float for once return;\"(){},<> = == & && | || ");
        push_text(src, "! != * *= + += - -= / /= .\n");
        send_source(src);
    endtask

    // The receiver holds off while the source keeps producing tokens, two for each "!;" pair.
    task automatic test_output_backpressure;
        logic [7:0] src[$];
        send_idle_en = 1'b0;
        recv_idle_en = 1'b1;
        hold_cycles  = 100;
        repeat (24) push_text(src, "!;");
        send_source(src);
    endtask

    // A long identifier whose last letters spell a keyword, then ordinary tokens.
    task automatic test_long_runs;
        logic [7:0] src[$];
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (200) src.push_back(random_letter());
        push_text(src, "return x;1.25");
        send_source(src);
    endtask

    task automatic test_random_sources;
        logic [7:0] src[$];
        logic [7:0] b;
        int         sent;
        sent = 0;
        while (sent < 975) begin
            src.delete();
            send_idle_en = ($urandom_range(0, 4) != 0);
            recv_idle_en = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 9))
                    0: begin
                        if ($urandom_range(0, 3) == 0)
                            src.push_back(random_letter());
                        push_text(src, keyword_words[$urandom_range(0, 6)]);
                        if ($urandom_range(0, 3) == 0)
                            src.push_back(random_letter());
                    end
                    1: begin
                        src.push_back(random_letter());
                        repeat ($urandom_range(0, 8)) begin
                            case ($urandom_range(0, 3))
                                0: src.push_back(random_letter());
                                1: src.push_back(random_digit());
                                2: src.push_back(8'h5F);
                                default: src.push_back(8'($urandom_range(0, 255)));
                            endcase
                        end
                    end
                    2: begin
                        src.push_back(random_digit());
                        repeat ($urandom_range(0, 6))
                            src.push_back($urandom_range(0, 3) == 0 ? CH_DOT : random_digit());
                    end
                    3: src.push_back(single_ops[$urandom_range(0, 7)]);
                    4: push_text(src, double_ops[$urandom_range(0, 7)]);
                    5: src.push_back(punct_chars[$urandom_range(0, 8)]);
                    6: begin
                        push_text(src, "//");
                        repeat ($urandom_range(0, 6)) begin
                            b = 8'($urandom_range(0, 255));
                            src.push_back(b == CH_NL ? CH_SPACE : b);
                        end
                        if ($urandom_range(0, 3) != 0)
                            src.push_back(CH_NL);
                    end
                    7: src.push_back(blank_bytes[$urandom_range(0, 6)]);
                    8: src.push_back(CH_DOT);
                    default: src.push_back(8'($urandom_range(0, 255)));
                endcase
                if ($urandom_range(0, 2) != 0)
                    src.push_back(CH_SPACE);
            end
            send_source(src);
            sent += src.size();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_all_kinds();
        test_output_backpressure();
        test_long_runs();
        test_random_sources();
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/stt_pkg.sv
rtl/core/source_text_tokenizer_unit.sv
tb/testbench.sv
